@@ hdl/dtsu_pkg.sv @@
// shared types, widths and codes of the deadline timer scheduler
package dtsu_pkg;

  localparam int unsigned NumTimersDefault = 32;

  // payload widths
  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdW   = 5;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DlW   = 33;
  localparam int unsigned SeqW  = 32;
  localparam int unsigned KindW = 2;

  // request commands
  typedef enum logic [CmdW-1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan_run;
    logic decide;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic req_scan;
    logic scan_done;
    logic rsp_last;
  } dp_status_t;

endpackage

@@ hdl/dtsu_if.sv @@
// request and result channel interfaces of the deadline timer scheduler
interface dtsu_req_if;
  logic                        valid;
  logic                        ready;
  logic [dtsu_pkg::CmdW-1:0]   command;
  logic [dtsu_pkg::IdW-1:0]    timer_id;
  logic [dtsu_pkg::TimeW-1:0]  timeout_ms;
  logic [dtsu_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, command, timer_id, timeout_ms, now_ms, input ready);
  modport sink   (input valid, command, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface dtsu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dtsu_pkg::KindW-1:0]  kind;
  logic [dtsu_pkg::IdW-1:0]    expired_id;
  logic [dtsu_pkg::DlW-1:0]    time_left_ms;
  logic                        queue_empty;
  logic                        last_result;

  modport source (output valid, kind, expired_id, time_left_ms, queue_empty, last_result,
                  input ready);
  modport sink   (input valid, kind, expired_id, time_left_ms, queue_empty, last_result,
                  output ready);
endinterface

@@ hdl/dtsu_ctrl.sv @@
// controller state machine: sequences take, table scan, decision and result hand-off
module dtsu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  input  dtsu_pkg::dp_status_t   status_i,
  output dtsu_pkg::ctl_t         ctl_o
);

  dtsu_pkg::state_e state_q, state_d;
  dtsu_pkg::ctl_t   ctl_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctl_d       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    case (state_q)
      dtsu_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_d.take = 1'b1;
          if (status_i.req_scan) begin
            ctl_d.scan_start = 1'b1;
            state_d          = dtsu_pkg::ST_SCAN;
          end else begin
            state_d = dtsu_pkg::ST_EMIT;
          end
        end
      end
      dtsu_pkg::ST_SCAN: begin
        ctl_d.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = dtsu_pkg::ST_DECIDE;
        end
      end
      dtsu_pkg::ST_DECIDE: begin
        ctl_d.decide = 1'b1;
        state_d      = dtsu_pkg::ST_EMIT;
      end
      dtsu_pkg::ST_EMIT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          if (status_i.rsp_last) begin
            state_d = dtsu_pkg::ST_IDLE;
          end else begin
            // more timers due: scan again for the next one
            ctl_d.scan_start = 1'b1;
            state_d          = dtsu_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = dtsu_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctl_o = ctl_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtsu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // query and expire requests always go through a scan
  a_scan_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o && status_i.req_scan |=> state_q == dtsu_pkg::ST_SCAN)
    else $error("scan request did not start a scan");

  // a decision is offered as a result in the next cycle
  a_decide_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.decide |=> rsp_valid_o)
    else $error("decision not presented as a result");

endmodule

@@ hdl/dtsu_dp.sv @@
// datapath: timer table, armed flags, min-deadline scan and result register
module dtsu_dp #(
  parameter int unsigned NUM_TIMERS = dtsu_pkg::NumTimersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtsu_pkg::ctl_t                ctl_i,
  output dtsu_pkg::dp_status_t          status_o,
  input  logic [dtsu_pkg::CmdW-1:0]     req_command_i,
  input  logic [dtsu_pkg::IdW-1:0]      req_timer_id_i,
  input  logic [dtsu_pkg::TimeW-1:0]    req_timeout_ms_i,
  input  logic [dtsu_pkg::TimeW-1:0]    req_now_ms_i,
  output logic [dtsu_pkg::KindW-1:0]    rsp_kind_o,
  output logic [dtsu_pkg::IdW-1:0]      rsp_expired_id_o,
  output logic [dtsu_pkg::DlW-1:0]      rsp_time_left_ms_o,
  output logic                          rsp_queue_empty_o,
  output logic                          rsp_last_result_o
);

  localparam int unsigned IdxW = $clog2(NUM_TIMERS);
  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned EntW = dtsu_pkg::DlW + dtsu_pkg::SeqW;
  localparam logic [CntW-1:0] CntEnd = CntW'(NUM_TIMERS);

  // table storage: deadline and arm sequence per timer
  logic [EntW-1:0] entry_mem [NUM_TIMERS];

  logic [NUM_TIMERS-1:0]        armed_q;
  logic [dtsu_pkg::SeqW-1:0]    seq_q;
  logic [CntW-1:0]              cnt_q;
  logic [CntW-1:0]              due_q;
  logic                         rd_vld_q;
  logic                         rd_armed_q;
  logic [IdxW-1:0]              rd_idx_q;
  logic [dtsu_pkg::DlW-1:0]     rd_dl_q;
  logic [dtsu_pkg::SeqW-1:0]    rd_seq_q;
  logic                         best_vld_q;
  logic [IdxW-1:0]              best_idx_q;
  logic [dtsu_pkg::DlW-1:0]     best_dl_q;
  logic [dtsu_pkg::SeqW-1:0]    best_seq_q;
  dtsu_pkg::cmd_e               cmd_q;
  logic [dtsu_pkg::TimeW-1:0]   now_q;
  dtsu_pkg::kind_e              kind_q;
  logic [dtsu_pkg::IdW-1:0]     id_q;
  logic [dtsu_pkg::DlW-1:0]     left_q;
  logic                         empty_q;
  logic                         last_q;

  dtsu_pkg::cmd_e               cmd_in;
  logic                         id_ok;
  logic [IdxW-1:0]              wr_idx;
  logic [IdxW-1:0]              cnt_idx;
  logic [dtsu_pkg::DlW-1:0]     new_dl;
  logic [dtsu_pkg::DlW-1:0]     now_ext;
  logic                         scanning;
  logic                         better;
  logic                         rd_due;
  logic                         best_due;
  logic                         do_arm;
  logic                         do_cancel;
  logic                         do_disarm;

  // request decode and compare logic
  always_comb begin
    cmd_in    = dtsu_pkg::cmd_e'(req_command_i);
    id_ok     = 32'(req_timer_id_i) < NUM_TIMERS;
    wr_idx    = IdxW'(req_timer_id_i);
    cnt_idx   = cnt_q[IdxW-1:0];
    new_dl    = {1'b0, req_now_ms_i} + {1'b0, req_timeout_ms_i};
    now_ext   = {1'b0, now_q};
    scanning  = ctl_i.scan_run && (cnt_q != CntEnd);
    // earlier deadline wins, newest arm wins a tie
    better    = rd_vld_q && rd_armed_q &&
                (!best_vld_q || (rd_dl_q < best_dl_q) ||
                 ((rd_dl_q == best_dl_q) && (rd_seq_q > best_seq_q)));
    rd_due    = rd_vld_q && rd_armed_q && (rd_dl_q <= now_ext);
    best_due  = best_vld_q && (best_dl_q <= now_ext);
    do_arm    = ctl_i.take && (cmd_in == dtsu_pkg::CMD_ARM) && id_ok;
    do_cancel = ctl_i.take && (cmd_in == dtsu_pkg::CMD_CANCEL) && id_ok;
    do_disarm = ctl_i.decide && (cmd_q == dtsu_pkg::CMD_EXPIRE) && best_due;
  end

  assign status_o.req_scan  = (cmd_in == dtsu_pkg::CMD_QUERY) ||
                              (cmd_in == dtsu_pkg::CMD_EXPIRE);
  assign status_o.scan_done = (cnt_q == CntEnd) && !rd_vld_q;
  assign status_o.rsp_last  = last_q;

  // table write on arm, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (do_arm) begin
      entry_mem[wr_idx] <= {new_dl, seq_q};
    end
    if (scanning) begin
      {rd_dl_q, rd_seq_q} <= entry_mem[cnt_idx];
    end
  end

  // armed flags and arm sequence counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      seq_q   <= '0;
    end else begin
      if (do_arm) begin
        armed_q[wr_idx] <= 1'b1;
        seq_q           <= seq_q + dtsu_pkg::SeqW'(1);
      end
      if (do_cancel) begin
        armed_q[wr_idx] <= 1'b0;
      end
      if (do_disarm) begin
        armed_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // scan sequencing, best-so-far flag and due count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      due_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_armed_q <= 1'b0;
      rd_idx_q   <= '0;
      best_vld_q <= 1'b0;
    end else if (ctl_i.scan_start) begin
      cnt_q      <= '0;
      due_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
    end else if (ctl_i.scan_run) begin
      if (scanning) begin
        rd_vld_q   <= 1'b1;
        rd_armed_q <= armed_q[cnt_idx];
        rd_idx_q   <= cnt_idx;
        cnt_q      <= cnt_q + CntW'(1);
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (better) begin
        best_vld_q <= 1'b1;
      end
      if (rd_due) begin
        due_q <= due_q + CntW'(1);
      end
    end
  end

  // best-so-far entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_run && better) begin
      best_idx_q <= rd_idx_q;
      best_dl_q  <= rd_dl_q;
      best_seq_q <= rd_seq_q;
    end
  end

  // request latch and result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q   <= cmd_in;
      now_q   <= req_now_ms_i;
      kind_q  <= dtsu_pkg::KIND_ACK;
      id_q    <= '0;
      left_q  <= '0;
      empty_q <= 1'b0;
      last_q  <= 1'b1;
    end else if (ctl_i.decide) begin
      id_q    <= '0;
      left_q  <= '0;
      empty_q <= 1'b0;
      last_q  <= 1'b1;
      case (cmd_q)
        dtsu_pkg::CMD_QUERY: begin
          kind_q <= dtsu_pkg::KIND_QUERY;
          if (!best_vld_q) begin
            empty_q <= 1'b1;
          end else if (best_dl_q > now_ext) begin
            left_q <= best_dl_q - now_ext;
          end
        end
        dtsu_pkg::CMD_EXPIRE: begin
          if (best_due) begin
            kind_q <= dtsu_pkg::KIND_EXPIRED;
            id_q   <= dtsu_pkg::IdW'(best_idx_q);
            last_q <= (due_q == CntW'(1));
          end else begin
            kind_q <= dtsu_pkg::KIND_NONE;
          end
        end
        default: begin
          kind_q <= dtsu_pkg::KIND_ACK;
        end
      endcase
    end
  end

  assign rsp_kind_o         = kind_q;
  assign rsp_expired_id_o   = id_q;
  assign rsp_time_left_ms_o = left_q;
  assign rsp_queue_empty_o  = empty_q;
  assign rsp_last_result_o  = last_q;

  // every accepted arm advances the sequence by one
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_arm |=> seq_q == $past(seq_q) + dtsu_pkg::SeqW'(1))
    else $error("arm sequence did not advance");

  // an emitted expiry leaves its timer disarmed
  a_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_disarm |=> !armed_q[$past(best_idx_q)])
    else $error("expired timer still armed");

  // any due timer seen in a finished scan means the earliest one is due
  a_due_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.scan_run && status_o.scan_done && (due_q != '0) |-> best_due)
    else $error("due timers counted but earliest entry not due");

endmodule

@@ hdl/deadline_timer_scheduler_unit.sv @@
// Deadline timer scheduler top level: up to NUM_TIMERS one-shot timers kept in a flat table.
// Arm and cancel requests are answered by an acknowledge offered in the cycle after they are taken.
// Query and expire requests scan the table one entry per cycle through the single read
// port of the deadline memory, then form the result in a decide step: a query gives one
// result, and an expire request scans the table anew for each result it emits (one per
// due timer, earliest deadline first, newest arm first on a tie).
// A new request is taken once the last result of the previous one has been handed off.
module deadline_timer_scheduler_unit #(
  parameter int unsigned NUM_TIMERS = dtsu_pkg::NumTimersDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtsu_req_if.sink   req_i,
  dtsu_rsp_if.source rsp_o
);

  dtsu_pkg::ctl_t       ctl;
  dtsu_pkg::dp_status_t status;

  // controller
  dtsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .ctl_o       (ctl)
  );

  // datapath
  dtsu_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .status_o           (status),
    .req_command_i      (req_i.command),
    .req_timer_id_i     (req_i.timer_id),
    .req_timeout_ms_i   (req_i.timeout_ms),
    .req_now_ms_i       (req_i.now_ms),
    .rsp_kind_o         (rsp_o.kind),
    .rsp_expired_id_o   (rsp_o.expired_id),
    .rsp_time_left_ms_o (rsp_o.time_left_ms),
    .rsp_queue_empty_o  (rsp_o.queue_empty),
    .rsp_last_result_o  (rsp_o.last_result)
  );

endmodule

@@ verif/deadline_timer_scheduler_unit_test.sv @@
// self-checking testbench of the deadline timer scheduler unit
`timescale 1ns / 1ps

module deadline_timer_scheduler_unit_test;

  localparam int unsigned NumTimers      = dtsu_pkg::NumTimersDefault;
  localparam realtime     ClkHalf        = 4.0;
  localparam int unsigned ResetCycles    = 5;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned RandomRequests = 400;
  localparam int unsigned DrainCycles    = NumTimers + 8;
  localparam int unsigned MaxResults     = 32;
  localparam int unsigned MaxReports     = 10;

  typedef struct packed {
    dtsu_pkg::cmd_e                  command;
    logic [dtsu_pkg::IdW-1:0]        timer_id;
    logic [dtsu_pkg::TimeW-1:0]      timeout_ms;
    logic [dtsu_pkg::TimeW-1:0]      now_ms;
  } timer_req_t;

  typedef struct packed {
    dtsu_pkg::kind_e                 kind;
    logic [dtsu_pkg::IdW-1:0]        expired_id;
    logic [dtsu_pkg::DlW-1:0]        time_left_ms;
    logic                            queue_empty;
    logic                            last_result;
  } timer_rsp_t;

  // one row of the directed table; rsp is only used when typed is set
  typedef struct packed {
    timer_req_t req;
    logic       typed;
    timer_rsp_t rsp;
  } step_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dtsu_req_if req_ch ();
  dtsu_rsp_if rsp_ch ();

  deadline_timer_scheduler_unit #(
    .NUM_TIMERS(NumTimers)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // timer table as the block should hold it
  logic                       timer_armed    [NumTimers];
  logic [dtsu_pkg::DlW-1:0]   timer_deadline [NumTimers];
  logic [dtsu_pkg::SeqW-1:0]  timer_seq      [NumTimers];
  logic [dtsu_pkg::SeqW-1:0]  arm_count;

  timer_rsp_t                 expected_rsp [$];
  step_t                      directed_steps [$];
  int unsigned                mismatches  = 0;
  int unsigned                idle_cycles = 0;
  bit                         steady      = 1'b0;
  logic [dtsu_pkg::TimeW-1:0] wall_ms;

  always #(ClkHalf) clk = ~clk;

  function automatic timer_req_t mk_req(dtsu_pkg::cmd_e command, int unsigned id,
                                        logic [dtsu_pkg::TimeW-1:0] timeout,
                                        logic [dtsu_pkg::TimeW-1:0] now);
    timer_req_t r;
    r.command    = command;
    r.timer_id   = id[dtsu_pkg::IdW-1:0];
    r.timeout_ms = timeout;
    r.now_ms     = now;
    return r;
  endfunction

  function automatic timer_rsp_t mk_rsp(dtsu_pkg::kind_e kind, int unsigned id,
                                        logic [dtsu_pkg::DlW-1:0] left,
                                        logic empty, logic last);
    timer_rsp_t s;
    s.kind         = kind;
    s.expired_id   = id[dtsu_pkg::IdW-1:0];
    s.time_left_ms = left;
    s.queue_empty  = empty;
    s.last_result  = last;
    return s;
  endfunction

  // earliest armed timer, newest arm wins a tie; -1 when none is armed
  function automatic int earliest_timer();
    int best;
    best = -1;
    for (int i = 0; i < NumTimers; i++) begin
      if (timer_armed[i] && (best < 0 || timer_deadline[i] < timer_deadline[best] ||
          (timer_deadline[i] == timer_deadline[best] && timer_seq[i] > timer_seq[best])))
        best = i;
    end
    return best;
  endfunction

  // update the timer table and queue the results one request causes
  function automatic void predict_timers(timer_req_t r);
    int                       best;
    int unsigned              count;
    logic [dtsu_pkg::DlW-1:0] now;
    timer_rsp_t               tail;
    count = 0;
    now   = {1'b0, r.now_ms};
    case (r.command)
      dtsu_pkg::CMD_ARM: begin
        if (r.timer_id < NumTimers) begin
          timer_armed[r.timer_id]    = 1'b1;
          timer_deadline[r.timer_id] = now + {1'b0, r.timeout_ms};
          timer_seq[r.timer_id]      = arm_count;
          arm_count                  = arm_count + 1'b1;
        end
        expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_ACK, 0, '0, 1'b0, 1'b1));
      end
      dtsu_pkg::CMD_CANCEL: begin
        if (r.timer_id < NumTimers) timer_armed[r.timer_id] = 1'b0;
        expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_ACK, 0, '0, 1'b0, 1'b1));
      end
      dtsu_pkg::CMD_QUERY: begin
        best = earliest_timer();
        if (best < 0) begin
          expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_QUERY, 0, '0, 1'b1, 1'b1));
        end else begin
          expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_QUERY, 0,
              (timer_deadline[best] > now) ? timer_deadline[best] - now : '0, 1'b0, 1'b1));
        end
      end
      default: begin
        best = earliest_timer();
        while (best >= 0 && count < MaxResults && timer_deadline[best] <= now) begin
          timer_armed[best] = 1'b0;
          expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_EXPIRED, best, '0, 1'b0, 1'b0));
          count++;
          best = earliest_timer();
        end
        if (count == 0) begin
          expected_rsp.push_back(mk_rsp(dtsu_pkg::KIND_NONE, 0, '0, 1'b0, 1'b1));
        end else begin
          tail = expected_rsp.pop_back();
          tail.last_result = 1'b1;
          expected_rsp.push_back(tail);
        end
      end
    endcase
  endfunction

  function automatic void add_step(timer_req_t r, logic typed, timer_rsp_t want);
    step_t s;
    s.req   = r;
    s.typed = typed;
    s.rsp   = want;
    directed_steps.push_back(s);
  endfunction

  function automatic logic [dtsu_pkg::TimeW-1:0] pick_timeout();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 300);
    if (roll < 92) return $urandom();
    if (roll < 96) return '0;
    return '1;
  endfunction

  function automatic logic [dtsu_pkg::TimeW-1:0] pick_now();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return wall_ms;
    if (roll < 97) return $urandom();
    return '1;
  endfunction

  // present one request, hold it until taken, then predict its results
  task automatic send_request(timer_req_t r, logic typed, timer_rsp_t want);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 10) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= r.command;
    req_ch.timer_id   <= r.timer_id;
    req_ch.timeout_ms <= r.timeout_ms;
    req_ch.now_ms     <= r.now_ms;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_timers(r);
    if (typed) begin
      void'(expected_rsp.pop_back());
      expected_rsp.push_back(want);
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    timer_rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: kind %0d id %0d left %0d empty %0b last %0b",
                   rsp_ch.kind, rsp_ch.expired_id, rsp_ch.time_left_ms,
                   rsp_ch.queue_empty, rsp_ch.last_result);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_ch.kind !== want.kind || rsp_ch.expired_id !== want.expired_id ||
            rsp_ch.time_left_ms !== want.time_left_ms ||
            rsp_ch.queue_empty !== want.queue_empty ||
            rsp_ch.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected kind %0d id %0d left %0d empty %0b last %0b",
                     want.kind, want.expired_id, want.time_left_ms,
                     want.queue_empty, want.last_result);
            $display("  actual   kind %0d id %0d left %0d empty %0b last %0b",
                     rsp_ch.kind, rsp_ch.expired_id, rsp_ch.time_left_ms,
                     rsp_ch.queue_empty, rsp_ch.last_result);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handoff
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    timer_rsp_t  ack;
    timer_rsp_t  none_due;
    timer_rsp_t  no_timer;
    int unsigned sent;
    int unsigned burst;
    int unsigned roll;

    ack      = mk_rsp(dtsu_pkg::KIND_ACK, 0, '0, 1'b0, 1'b1);
    none_due = mk_rsp(dtsu_pkg::KIND_NONE, 0, '0, 1'b0, 1'b1);
    no_timer = mk_rsp(dtsu_pkg::KIND_QUERY, 0, '0, 1'b1, 1'b1);

    req_ch.valid      = 1'b0;
    req_ch.command    = dtsu_pkg::CMD_ARM;
    req_ch.timer_id   = '0;
    req_ch.timeout_ms = '0;
    req_ch.now_ms     = '0;
    arm_count         = '0;
    for (int i = 0; i < NumTimers; i++) begin
      timer_armed[i]    = 1'b0;
      timer_deadline[i] = '0;
      timer_seq[i]      = '0;
    end

    // directed part: empty table, extremes, tie order, re-arm, clamp
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, '0), 1'b1, no_timer);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, '0), 1'b1, none_due);
    add_step(mk_req(dtsu_pkg::CMD_CANCEL, 5, '0, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 0, '0, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 31, '1, '1), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 1, 32'd100, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 2, 32'd100, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, '0), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, 32'd5), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, '0), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, 32'd10), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 1, 32'd50, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, 32'd100), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, '0), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, '1), 1'b1, none_due);
    add_step(mk_req(dtsu_pkg::CMD_CANCEL, 31, '0, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_QUERY, 0, '0, 32'd77), 1'b1, no_timer);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 7, '0, '1), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 8, '0, '1), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_ARM, 9, 32'd3, 32'hFFFF_FFFC), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, '1), 1'b0, ack);
    add_step(mk_req(dtsu_pkg::CMD_CANCEL, 9, '0, '0), 1'b1, ack);
    add_step(mk_req(dtsu_pkg::CMD_EXPIRE, 0, '0, '1), 1'b1, none_due);

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[i])
      send_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].rsp);

    // random part: a slowly advancing clock so that timers come due
    wall_ms = 32'd1000;
    sent    = 0;
    while (sent < RandomRequests) begin
      steady = (sent >= 150 && sent < 250);
      roll   = $urandom_range(0, 99);
      if (roll < 6) begin
        // arm a batch close together, then expire them all at once
        burst = $urandom_range(4, NumTimers);
        for (int k = 0; k < burst; k++)
          send_request(mk_req(dtsu_pkg::CMD_ARM, $urandom_range(0, NumTimers - 1),
                              $urandom_range(0, 20), wall_ms), 1'b0, ack);
        wall_ms = wall_ms + 20;
        send_request(mk_req(dtsu_pkg::CMD_EXPIRE, $urandom_range(0, NumTimers - 1),
                            $urandom(), wall_ms), 1'b0, ack);
        sent += burst + 1;
      end else if (roll < 45) begin
        send_request(mk_req(dtsu_pkg::CMD_ARM, $urandom_range(0, NumTimers - 1),
                            pick_timeout(), pick_now()), 1'b0, ack);
        sent++;
      end else if (roll < 60) begin
        send_request(mk_req(dtsu_pkg::CMD_CANCEL, $urandom_range(0, NumTimers - 1),
                            $urandom(), $urandom()), 1'b0, ack);
        sent++;
      end else if (roll < 76) begin
        send_request(mk_req(dtsu_pkg::CMD_QUERY, $urandom_range(0, NumTimers - 1),
                            $urandom(), pick_now()), 1'b0, ack);
        sent++;
      end else begin
        send_request(mk_req(dtsu_pkg::CMD_EXPIRE, $urandom_range(0, NumTimers - 1),
                            $urandom(), pick_now()), 1'b0, ack);
        sent++;
      end
      wall_ms = wall_ms + $urandom_range(0, 40);
      if ($urandom_range(0, 99) < 3) wall_ms = $urandom();
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    // drain outstanding results, then watch for strays
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ deadline_timer_scheduler_unit.f @@
hdl/dtsu_pkg.sv
hdl/dtsu_if.sv
hdl/dtsu_ctrl.sv
hdl/dtsu_dp.sv
hdl/deadline_timer_scheduler_unit.sv
verif/deadline_timer_scheduler_unit_test.sv
